/* rtl/pcgt_pkg.sv */
// ----------------------------------------------------------------------------
// Program-change gate trigger package
// Shared constants, state machine type and the command and status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pcgt_pkg;

   localparam int SLOT_COUNT_DEF  = 10;
   localparam int GATE_FRAMES_DEF = 4800;
   localparam int BUS_COUNT_DEF   = 28;

   localparam int CFG_SLOTS  = 10;
   localparam int HALF_SLOTS = 5;
   localparam int PROG_W     = 7;
   localparam int NOTE_W     = 7;
   localparam int SLOT_BUS_W = 5;
   localparam int CD_W       = 13;
   localparam int FRAMES_W   = 10;
   localparam int BUS_OUT_W  = 28;
   localparam int WIDE_REG_W = 35;
   localparam int BUS_REG_W  = 25;
   localparam int CHAN_W     = 5;
   localparam int DEST_W     = 3;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_PROGRAM_LO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROGRAM_HI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NOTE_LO    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NOTE_HI    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUS_LO     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BUS_HI     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DEST       = 3'd7;

   localparam logic [WIDE_REG_W-1:0] PROGRAM_LO_RST = 35'd545392672;
   localparam logic [WIDE_REG_W-1:0] PROGRAM_HI_RST = 35'd17317316613;
   localparam logic [WIDE_REG_W-1:0] NOTE_LO_RST    = 35'd18071060412;
   localparam logic [WIDE_REG_W-1:0] NOTE_HI_RST    = 35'd20461011397;
   localparam logic [BUS_REG_W-1:0]  BUS_LO_RST     = 25'd0;
   localparam logic [BUS_REG_W-1:0]  BUS_HI_RST     = 25'd0;
   localparam logic [CHAN_W-1:0]     CHANNEL_RST    = 5'd1;
   localparam logic [DEST_W-1:0]     DEST_RST       = 3'd3;

   localparam logic       CMD_MIDI      = 1'b0;
   localparam logic       CMD_TICK      = 1'b1;
   localparam logic [3:0] STATUS_PC_HI  = 4'hC;
   localparam logic [7:0] NOTE_ON_BASE  = 8'h90;
   localparam logic [7:0] NOTE_OFF_BASE = 8'h80;
   localparam logic [6:0] VEL_ON        = 7'd100;
   localparam logic [6:0] VEL_OFF       = 7'd0;
   localparam logic [DEST_W-1:0] DEST_MAX = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } pcgt_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic emit;
      logic emit_none;
   } pcgt_cmd_type;

   typedef struct packed {
      logic out_free;
      logic emit_hit;
      logic emit_last;
      logic mask_empty;
   } pcgt_stat_type;

endpackage

/* rtl/program_change_gate_trigger.sv */
// ----------------------------------------------------------------------------
// Program-change gate trigger
// Ten slots map MIDI program changes to timed gates, bus levels and notes.
// ----------------------------------------------------------------------------
// A request on the req_ channel is either a MIDI message or an audio block
// tick. Each request yields one or more results on the rsp_ channel, the
// final one marked by rsp_last. A request that sends no note yields a single
// status-only result carrying the bus levels.
// After a request is accepted the block walks its slots, one per cycle.
// Emission then walks the slots up to the last slot that sends a note, or
// loads a single status-only result. The next request is accepted in the
// cycle after the last result has been loaded into the output register.
// While the receiver holds rsp_stall, the current result stays in the
// output register and emission pauses. Configuration is written through
// the csr_ channel, which is always ready; the user must write it only
// while no request is in flight, as the block itself does not enforce it.
// Reset clears all gates, countdowns and note flags and restores the
// configuration to its default values.
// ----------------------------------------------------------------------------
module program_change_gate_trigger #(
   parameter int SLOT_COUNT  = pcgt_pkg::SLOT_COUNT_DEF,
   parameter int GATE_FRAMES = pcgt_pkg::GATE_FRAMES_DEF,
   parameter int BUS_COUNT   = pcgt_pkg::BUS_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [7:0]                      req_status_byte,
   input  logic [6:0]                      req_data_byte,
   input  logic [7:0]                      req_block_quads,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_message_valid,
   output logic [7:0]                      rsp_note_status,
   output logic [6:0]                      rsp_note_number,
   output logic [6:0]                      rsp_velocity,
   output logic [2:0]                      rsp_port_select,
   output logic [pcgt_pkg::BUS_OUT_W-1:0]  rsp_bus_levels,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pcgt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcgt_pkg::WIDE_REG_W-1:0] csr_data
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   pcgt_pkg::pcgt_cmd_type  cmd;
   pcgt_pkg::pcgt_stat_type stat;
   logic [IDX_W-1:0]        slot_idx;

   assign csr_ready = 1'b1;

   pcgt_ctrl #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd),
      .slot_idx  (slot_idx)
   );

   pcgt_datapath #(
      .SLOT_COUNT  (SLOT_COUNT),
      .GATE_FRAMES (GATE_FRAMES),
      .BUS_COUNT   (BUS_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .slot_idx          (slot_idx),
      .stat              (stat),
      .req_command       (req_command),
      .req_status_byte   (req_status_byte),
      .req_data_byte     (req_data_byte),
      .req_block_quads   (req_block_quads),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_message_valid (rsp_message_valid),
      .rsp_note_status   (rsp_note_status),
      .rsp_note_number   (rsp_note_number),
      .rsp_velocity      (rsp_velocity),
      .rsp_port_select   (rsp_port_select),
      .rsp_bus_levels    (rsp_bus_levels),
      .rsp_last          (rsp_last),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while the previous one was still in progress");

   a_status_only_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_message_valid |-> rsp_last)
      else $error("status-only result not marked as last");

   a_note_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_valid |->
         rsp_port_select != 3'd0 &&
         (((rsp_note_status & 8'hF0) == pcgt_pkg::NOTE_ON_BASE &&
           rsp_velocity == pcgt_pkg::VEL_ON) ||
          ((rsp_note_status & 8'hF0) == pcgt_pkg::NOTE_OFF_BASE &&
           rsp_velocity == pcgt_pkg::VEL_OFF)))
      else $error("note result with inconsistent status, velocity or port");

endmodule

/* rtl/pcgt_ctrl.sv */
// ----------------------------------------------------------------------------
// Program-change gate trigger controller
// Sequences each request through a slot scan and a result emission walk.
// ----------------------------------------------------------------------------
module pcgt_ctrl #(
   parameter int SLOT_COUNT = pcgt_pkg::SLOT_COUNT_DEF,
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pcgt_pkg::pcgt_stat_type stat,
   output pcgt_pkg::pcgt_cmd_type  cmd,
   output logic [IDX_W-1:0]       slot_idx
);

   pcgt_pkg::pcgt_state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcgt_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         pcgt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = pcgt_pkg::ST_SCAN;
            end
         end
         pcgt_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (idx_ff == IDX_W'(SLOT_COUNT - 1)) begin
               idx_in   = '0;
               state_in = pcgt_pkg::ST_EMIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         pcgt_pkg::ST_EMIT: begin
            if (stat.mask_empty) begin
               if (stat.out_free) begin
                  cmd.emit_none = 1'b1;
                  state_in      = pcgt_pkg::ST_IDLE;
               end
            end else if (!stat.emit_hit) begin
               idx_in = idx_ff + IDX_W'(1);
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.emit_last) begin
                  state_in = pcgt_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = pcgt_pkg::ST_IDLE;
         end
      endcase
   end

   assign slot_idx = idx_ff;

endmodule

/* rtl/pcgt_datapath.sv */
// ----------------------------------------------------------------------------
// Program-change gate trigger datapath
// Configuration registers, per-slot gate state, the emit mask, the bus
// level accumulator and the result register.
// ----------------------------------------------------------------------------
module pcgt_datapath #(
   parameter int SLOT_COUNT  = pcgt_pkg::SLOT_COUNT_DEF,
   parameter int GATE_FRAMES = pcgt_pkg::GATE_FRAMES_DEF,
   parameter int BUS_COUNT   = pcgt_pkg::BUS_COUNT_DEF,
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pcgt_pkg::pcgt_cmd_type               cmd,
   input  logic [IDX_W-1:0]                     slot_idx,
   output pcgt_pkg::pcgt_stat_type              stat,
   input  logic                                 req_command,
   input  logic [7:0]                           req_status_byte,
   input  logic [6:0]                           req_data_byte,
   input  logic [7:0]                           req_block_quads,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_message_valid,
   output logic [7:0]                           rsp_note_status,
   output logic [6:0]                           rsp_note_number,
   output logic [6:0]                           rsp_velocity,
   output logic [2:0]                           rsp_port_select,
   output logic [pcgt_pkg::BUS_OUT_W-1:0]       rsp_bus_levels,
   output logic                                 rsp_last,
   input  logic                                 csr_write,
   input  logic [pcgt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcgt_pkg::WIDE_REG_W-1:0]      csr_data
);

   logic [pcgt_pkg::WIDE_REG_W-1:0] program_lo_ff, program_hi_ff, note_lo_ff, note_hi_ff;
   logic [pcgt_pkg::BUS_REG_W-1:0]  bus_lo_ff, bus_hi_ff;
   logic [pcgt_pkg::CHAN_W-1:0]     channel_ff;
   logic [pcgt_pkg::DEST_W-1:0]     dest_ff;

   logic                            command_ff;
   logic                            is_pc_ff;
   logic [6:0]                      program_ff;
   logic [7:0]                      quads_ff;

   logic [pcgt_pkg::CD_W-1:0]       countdown_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]           gate_ff;
   logic [SLOT_COUNT-1:0]           sounding_ff;
   logic [SLOT_COUNT-1:0]           emit_mask_ff;
   logic [BUS_COUNT-1:0]            bus_acc_ff;

   logic                            rsp_valid_ff;
   logic                            msg_valid_ff;
   logic [7:0]                      note_status_ff;
   logic [6:0]                      note_number_ff;
   logic [6:0]                      velocity_ff;
   logic [2:0]                      port_select_ff;
   logic [pcgt_pkg::BUS_OUT_W-1:0]  bus_levels_ff;
   logic                            last_ff;

   logic [pcgt_pkg::PROG_W-1:0]     prog_tab [pcgt_pkg::CFG_SLOTS];
   logic [pcgt_pkg::NOTE_W-1:0]     note_tab [pcgt_pkg::CFG_SLOTS];
   logic [pcgt_pkg::SLOT_BUS_W-1:0] bus_tab  [pcgt_pkg::CFG_SLOTS];

   logic                            cfg_ok;
   logic [pcgt_pkg::PROG_W-1:0]     prog_sel;
   logic [pcgt_pkg::NOTE_W-1:0]     note_sel;
   logic [pcgt_pkg::SLOT_BUS_W-1:0] bus_sel;
   logic [pcgt_pkg::DEST_W-1:0]     port;
   logic [pcgt_pkg::CD_W-1:0]       cd_sel, cd_new;
   logic [pcgt_pkg::CD_W-1:0]       frames;
   logic                            gate_new, sounding_new, emit_new;
   logic [pcgt_pkg::CHAN_W-1:0]     chan_m1;
   logic [SLOT_COUNT-1:0]           mask_above;

   always_comb begin
      for (int s = 0; s < pcgt_pkg::HALF_SLOTS; s++) begin
         prog_tab[s] = program_lo_ff[s*pcgt_pkg::PROG_W +: pcgt_pkg::PROG_W];
         prog_tab[s+pcgt_pkg::HALF_SLOTS] = program_hi_ff[s*pcgt_pkg::PROG_W +: pcgt_pkg::PROG_W];
         note_tab[s] = note_lo_ff[s*pcgt_pkg::NOTE_W +: pcgt_pkg::NOTE_W];
         note_tab[s+pcgt_pkg::HALF_SLOTS] = note_hi_ff[s*pcgt_pkg::NOTE_W +: pcgt_pkg::NOTE_W];
         bus_tab[s] = bus_lo_ff[s*pcgt_pkg::SLOT_BUS_W +: pcgt_pkg::SLOT_BUS_W];
         bus_tab[s+pcgt_pkg::HALF_SLOTS] = bus_hi_ff[s*pcgt_pkg::SLOT_BUS_W +: pcgt_pkg::SLOT_BUS_W];
      end
   end

   always_comb begin
      cfg_ok   = int'(slot_idx) < pcgt_pkg::CFG_SLOTS;
      prog_sel = '0;
      note_sel = '0;
      bus_sel  = '0;
      if (cfg_ok) begin
         prog_sel = prog_tab[int'(slot_idx)];
         note_sel = note_tab[int'(slot_idx)];
         bus_sel  = bus_tab[int'(slot_idx)];
      end
   end

   assign port = (dest_ff >= pcgt_pkg::DEST_W'(1) && dest_ff <= pcgt_pkg::DEST_MAX) ?
                 dest_ff : '0;
   assign chan_m1 = channel_ff - pcgt_pkg::CHAN_W'(1);
   assign frames  = pcgt_pkg::CD_W'({quads_ff, 2'b00});
   assign cd_sel  = countdown_ff[slot_idx];

   always_comb begin
      cd_new       = cd_sel;
      gate_new     = gate_ff[slot_idx];
      sounding_new = sounding_ff[slot_idx];
      emit_new     = 1'b0;
      if (command_ff == pcgt_pkg::CMD_MIDI) begin
         if (cfg_ok && is_pc_ff && prog_sel == program_ff) begin
            cd_new   = pcgt_pkg::CD_W'(GATE_FRAMES);
            gate_new = 1'b1;
            if (port != '0) begin
               sounding_new = 1'b1;
               emit_new     = 1'b1;
            end
         end
      end else if (cd_sel != '0) begin
         if (cd_sel <= frames) begin
            cd_new   = '0;
            gate_new = 1'b0;
            if (sounding_new && port != '0) begin
               sounding_new = 1'b0;
               emit_new     = 1'b1;
            end
         end else begin
            cd_new = cd_sel - frames;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         program_lo_ff <= pcgt_pkg::PROGRAM_LO_RST;
         program_hi_ff <= pcgt_pkg::PROGRAM_HI_RST;
         note_lo_ff    <= pcgt_pkg::NOTE_LO_RST;
         note_hi_ff    <= pcgt_pkg::NOTE_HI_RST;
         bus_lo_ff     <= pcgt_pkg::BUS_LO_RST;
         bus_hi_ff     <= pcgt_pkg::BUS_HI_RST;
         channel_ff    <= pcgt_pkg::CHANNEL_RST;
         dest_ff       <= pcgt_pkg::DEST_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            pcgt_pkg::REG_PROGRAM_LO: program_lo_ff <= csr_data;
            pcgt_pkg::REG_PROGRAM_HI: program_hi_ff <= csr_data;
            pcgt_pkg::REG_NOTE_LO:    note_lo_ff    <= csr_data;
            pcgt_pkg::REG_NOTE_HI:    note_hi_ff    <= csr_data;
            pcgt_pkg::REG_BUS_LO:     bus_lo_ff     <= csr_data[pcgt_pkg::BUS_REG_W-1:0];
            pcgt_pkg::REG_BUS_HI:     bus_hi_ff     <= csr_data[pcgt_pkg::BUS_REG_W-1:0];
            pcgt_pkg::REG_CHANNEL:    channel_ff    <= csr_data[pcgt_pkg::CHAN_W-1:0];
            pcgt_pkg::REG_DEST:       dest_ff       <= csr_data[pcgt_pkg::DEST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         is_pc_ff   <= req_status_byte[7:4] == pcgt_pkg::STATUS_PC_HI;
         program_ff <= req_data_byte;
         quads_ff   <= req_block_quads;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            countdown_ff[s] <= '0;
         end
         gate_ff      <= '0;
         sounding_ff  <= '0;
         emit_mask_ff <= '0;
         bus_acc_ff   <= '0;
      end else if (cmd.load) begin
         emit_mask_ff <= '0;
         bus_acc_ff   <= '0;
      end else if (cmd.scan) begin
         countdown_ff[slot_idx] <= cd_new;
         gate_ff[slot_idx]      <= gate_new;
         sounding_ff[slot_idx]  <= sounding_new;
         emit_mask_ff[slot_idx] <= emit_new;
         for (int j = 0; j < BUS_COUNT; j++) begin
            if (cfg_ok && bus_sel == pcgt_pkg::SLOT_BUS_W'(j + 1)) begin
               bus_acc_ff[j] <= gate_new;
            end
         end
      end
   end

   assign mask_above = (emit_mask_ff >> slot_idx) >> 1;

   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.emit_hit   = emit_mask_ff[slot_idx];
   assign stat.emit_last  = mask_above == '0;
   assign stat.mask_empty = emit_mask_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_none) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         msg_valid_ff   <= 1'b1;
         note_status_ff <= ((command_ff == pcgt_pkg::CMD_TICK) ?
                            pcgt_pkg::NOTE_OFF_BASE : pcgt_pkg::NOTE_ON_BASE) |
                           {4'b0000, chan_m1[3:0]};
         note_number_ff <= note_sel;
         velocity_ff    <= (command_ff == pcgt_pkg::CMD_TICK) ?
                           pcgt_pkg::VEL_OFF : pcgt_pkg::VEL_ON;
         port_select_ff <= port;
         bus_levels_ff  <= pcgt_pkg::BUS_OUT_W'(bus_acc_ff);
         last_ff        <= stat.emit_last;
      end else if (cmd.emit_none) begin
         msg_valid_ff   <= 1'b0;
         note_status_ff <= '0;
         note_number_ff <= '0;
         velocity_ff    <= '0;
         port_select_ff <= '0;
         bus_levels_ff  <= pcgt_pkg::BUS_OUT_W'(bus_acc_ff);
         last_ff        <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_message_valid = msg_valid_ff;
   assign rsp_note_status   = note_status_ff;
   assign rsp_note_number   = note_number_ff;
   assign rsp_velocity      = velocity_ff;
   assign rsp_port_select   = port_select_ff;
   assign rsp_bus_levels    = bus_levels_ff;
   assign rsp_last          = last_ff;

endmodule

/* dv/program_change_gate_trigger_tb.sv */
// ----------------------------------------------------------------------------
// Program-change gate trigger testbench
// Drives MIDI program changes and audio block ticks into the block, keeps its
// own model of the slot gates, countdowns and note flags, and checks every
// note message and status result with its bus levels against that model.
// ----------------------------------------------------------------------------
module program_change_gate_trigger_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 60;

   typedef struct packed {
      logic                           message_valid;
      logic [7:0]                     note_status;
      logic [6:0]                     note_number;
      logic [6:0]                     velocity;
      logic [2:0]                     port_select;
      logic [pcgt_pkg::BUS_OUT_W-1:0] bus_levels;
      logic                           last;
   } note_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid       = 1'b0;
   logic                            req_stall;
   logic                            req_command     = 1'b0;
   logic [7:0]                      req_status_byte = 8'd0;
   logic [6:0]                      req_data_byte   = 7'd0;
   logic [7:0]                      req_block_quads = 8'd0;
   logic                            rsp_valid;
   logic                            rsp_stall       = 1'b0;
   logic                            rsp_message_valid;
   logic [7:0]                      rsp_note_status;
   logic [6:0]                      rsp_note_number;
   logic [6:0]                      rsp_velocity;
   logic [2:0]                      rsp_port_select;
   logic [pcgt_pkg::BUS_OUT_W-1:0]  rsp_bus_levels;
   logic                            rsp_last;
   logic                            csr_valid       = 1'b0;
   logic                            csr_ready;
   logic [pcgt_pkg::CSR_IDX_W-1:0]  csr_index       = '0;
   logic [pcgt_pkg::WIDE_REG_W-1:0] csr_data        = '0;

   logic [pcgt_pkg::WIDE_REG_W-1:0] cfg_prog_lo = pcgt_pkg::PROGRAM_LO_RST;
   logic [pcgt_pkg::WIDE_REG_W-1:0] cfg_prog_hi = pcgt_pkg::PROGRAM_HI_RST;
   logic [pcgt_pkg::WIDE_REG_W-1:0] cfg_note_lo = pcgt_pkg::NOTE_LO_RST;
   logic [pcgt_pkg::WIDE_REG_W-1:0] cfg_note_hi = pcgt_pkg::NOTE_HI_RST;
   logic [pcgt_pkg::BUS_REG_W-1:0]  cfg_bus_lo  = pcgt_pkg::BUS_LO_RST;
   logic [pcgt_pkg::BUS_REG_W-1:0]  cfg_bus_hi  = pcgt_pkg::BUS_HI_RST;
   logic [pcgt_pkg::CHAN_W-1:0]     cfg_chan    = pcgt_pkg::CHANNEL_RST;
   logic [pcgt_pkg::DEST_W-1:0]     cfg_dest    = pcgt_pkg::DEST_RST;

   int   gate_count [pcgt_pkg::CFG_SLOTS] = '{default: 0};
   logic gate_on    [pcgt_pkg::CFG_SLOTS] = '{default: 1'b0};
   logic note_held  [pcgt_pkg::CFG_SLOTS] = '{default: 1'b0};

   note_event_type pending_events[$];
   int             mismatches     = 0;
   int             req_gap_odds   = 20;
   int             rsp_stall_odds = 20;
   logic [6:0]     program_pool [4];

   program_change_gate_trigger dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_status_byte   (req_status_byte),
      .req_data_byte     (req_data_byte),
      .req_block_quads   (req_block_quads),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_message_valid (rsp_message_valid),
      .rsp_note_status   (rsp_note_status),
      .rsp_note_number   (rsp_note_number),
      .rsp_velocity      (rsp_velocity),
      .rsp_port_select   (rsp_port_select),
      .rsp_bus_levels    (rsp_bus_levels),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] slot7(logic [pcgt_pkg::WIDE_REG_W-1:0] lo,
                                        logic [pcgt_pkg::WIDE_REG_W-1:0] hi, int s);
      logic [pcgt_pkg::WIDE_REG_W-1:0] w;
      w = (s < pcgt_pkg::HALF_SLOTS) ? lo >> (pcgt_pkg::PROG_W * s)
                                     : hi >> (pcgt_pkg::PROG_W * (s - pcgt_pkg::HALF_SLOTS));
      return w[6:0];
   endfunction

   function automatic logic [4:0] slot_bus(int s);
      logic [pcgt_pkg::BUS_REG_W-1:0] w;
      w = (s < pcgt_pkg::HALF_SLOTS)
          ? cfg_bus_lo >> (pcgt_pkg::SLOT_BUS_W * s)
          : cfg_bus_hi >> (pcgt_pkg::SLOT_BUS_W * (s - pcgt_pkg::HALF_SLOTS));
      return w[4:0];
   endfunction

   function automatic note_event_type note_msg(logic [7:0] base, int s, logic [6:0] vel,
                                               logic [2:0] port);
      note_event_type              ev;
      logic [pcgt_pkg::CHAN_W-1:0] chan_m1;
      chan_m1          = cfg_chan - 5'd1;
      ev               = '0;
      ev.message_valid = 1'b1;
      ev.note_status   = base | {4'h0, chan_m1[3:0]};
      ev.note_number   = slot7(cfg_note_lo, cfg_note_hi, s);
      ev.velocity      = vel;
      ev.port_select   = port;
      return ev;
   endfunction

   task automatic predict_gate_events(logic cmd, logic [7:0] status, logic [6:0] data,
                                      logic [7:0] quads);
      note_event_type                 batch[$];
      note_event_type                 ev;
      logic [2:0]                     port;
      logic [pcgt_pkg::BUS_OUT_W-1:0] levels;
      logic [4:0]                     bus;
      int                             frames;
      port = (cfg_dest >= 3'd1 && cfg_dest <= pcgt_pkg::DEST_MAX) ? cfg_dest : 3'd0;
      if (cmd == pcgt_pkg::CMD_MIDI) begin
         if (status[7:4] == pcgt_pkg::STATUS_PC_HI) begin
            for (int s = 0; s < pcgt_pkg::CFG_SLOTS; s++) begin
               if (slot7(cfg_prog_lo, cfg_prog_hi, s) == data) begin
                  gate_count[s] = pcgt_pkg::GATE_FRAMES_DEF;
                  gate_on[s]    = 1'b1;
                  if (port != 3'd0) begin
                     batch.push_back(note_msg(pcgt_pkg::NOTE_ON_BASE, s, pcgt_pkg::VEL_ON,
                                              port));
                     note_held[s] = 1'b1;
                  end
               end
            end
         end
      end else begin
         frames = int'(quads) * 4;
         for (int s = 0; s < pcgt_pkg::CFG_SLOTS; s++) begin
            if (gate_count[s] > 0) begin
               gate_count[s] -= frames;
               if (gate_count[s] <= 0) begin
                  gate_count[s] = 0;
                  gate_on[s]    = 1'b0;
                  if (note_held[s] && port != 3'd0) begin
                     batch.push_back(note_msg(pcgt_pkg::NOTE_OFF_BASE, s, pcgt_pkg::VEL_OFF,
                                              port));
                     note_held[s] = 1'b0;
                  end
               end
            end
         end
      end
      if (batch.size() == 0) begin
         ev = '0;
         batch.push_back(ev);
      end
      levels = '0;
      for (int s = 0; s < pcgt_pkg::CFG_SLOTS; s++) begin
         bus = slot_bus(s);
         if (bus >= 5'd1 && bus <= pcgt_pkg::BUS_COUNT_DEF) levels[bus - 1] = gate_on[s];
      end
      for (int k = 0; k < batch.size(); k++) begin
         ev            = batch[k];
         ev.bus_levels = levels;
         ev.last       = (k == batch.size() - 1);
         pending_events.push_back(ev);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
   endtask

   always @(posedge clock) begin : check_results
      note_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_bus_levels), 32'd0);
         end else begin
            want = pending_events.pop_front();
            if (rsp_message_valid !== want.message_valid)
               report_mismatch("message_valid", 32'(rsp_message_valid),
                               32'(want.message_valid));
            if (rsp_note_status !== want.note_status)
               report_mismatch("note_status", 32'(rsp_note_status), 32'(want.note_status));
            if (rsp_note_number !== want.note_number)
               report_mismatch("note_number", 32'(rsp_note_number), 32'(want.note_number));
            if (rsp_velocity !== want.velocity)
               report_mismatch("velocity", 32'(rsp_velocity), 32'(want.velocity));
            if (rsp_port_select !== want.port_select)
               report_mismatch("port_select", 32'(rsp_port_select), 32'(want.port_select));
            if (rsp_bus_levels !== want.bus_levels)
               report_mismatch("bus_levels", 32'(rsp_bus_levels), 32'(want.bus_levels));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   initial begin : rsp_backpressure
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold == 0 && rsp_stall_odds > 0 && $urandom_range(1, 100) <= rsp_stall_odds)
            hold = $urandom_range(1, 7);
         rsp_stall = (hold > 0);
         if (hold > 0) hold--;
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_item(logic cmd, logic [7:0] status, logic [6:0] data, logic [7:0] quads);
      @(negedge clock);
      if (req_gap_odds > 0 && $urandom_range(1, 100) <= req_gap_odds) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_command     = cmd;
      req_status_byte = status;
      req_data_byte   = data;
      req_block_quads = quads;
      do @(posedge clock); while (req_stall);
      predict_gate_events(cmd, status, data, quads);
   endtask

   task automatic send_tick(logic [7:0] quads);
      send_item(pcgt_pkg::CMD_TICK, 8'($urandom), 7'($urandom), quads);
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [pcgt_pkg::CSR_IDX_W-1:0] idx,
                            logic [pcgt_pkg::WIDE_REG_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pcgt_pkg::REG_PROGRAM_LO: cfg_prog_lo = value;
         pcgt_pkg::REG_PROGRAM_HI: cfg_prog_hi = value;
         pcgt_pkg::REG_NOTE_LO:    cfg_note_lo = value;
         pcgt_pkg::REG_NOTE_HI:    cfg_note_hi = value;
         pcgt_pkg::REG_BUS_LO:     cfg_bus_lo  = value[pcgt_pkg::BUS_REG_W-1:0];
         pcgt_pkg::REG_BUS_HI:     cfg_bus_hi  = value[pcgt_pkg::BUS_REG_W-1:0];
         pcgt_pkg::REG_CHANNEL:    cfg_chan    = value[pcgt_pkg::CHAN_W-1:0];
         pcgt_pkg::REG_DEST:       cfg_dest    = value[pcgt_pkg::DEST_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_settings(logic [pcgt_pkg::WIDE_REG_W-1:0] prog_lo,
                                 logic [pcgt_pkg::WIDE_REG_W-1:0] prog_hi,
                                 logic [pcgt_pkg::WIDE_REG_W-1:0] note_lo,
                                 logic [pcgt_pkg::WIDE_REG_W-1:0] note_hi,
                                 logic [pcgt_pkg::WIDE_REG_W-1:0] bus_lo,
                                 logic [pcgt_pkg::WIDE_REG_W-1:0] bus_hi,
                                 logic [pcgt_pkg::WIDE_REG_W-1:0] chan,
                                 logic [pcgt_pkg::WIDE_REG_W-1:0] dest);
      settle_block();
      write_reg(pcgt_pkg::REG_PROGRAM_LO, prog_lo);
      write_reg(pcgt_pkg::REG_PROGRAM_HI, prog_hi);
      write_reg(pcgt_pkg::REG_NOTE_LO, note_lo);
      write_reg(pcgt_pkg::REG_NOTE_HI, note_hi);
      write_reg(pcgt_pkg::REG_BUS_LO, bus_lo);
      write_reg(pcgt_pkg::REG_BUS_HI, bus_hi);
      write_reg(pcgt_pkg::REG_CHANNEL, chan);
      write_reg(pcgt_pkg::REG_DEST, dest);
   endtask

   function automatic logic [6:0] pick_program();
      if ($urandom_range(0, 7) == 0) return 7'($urandom);
      return program_pool[2'($urandom_range(0, 3))];
   endfunction

   task automatic test_program_match();
      send_item(pcgt_pkg::CMD_MIDI, 8'hC0, slot7(cfg_prog_lo, cfg_prog_hi, 0), 8'd0);
      send_item(pcgt_pkg::CMD_MIDI, 8'hCF, slot7(cfg_prog_lo, cfg_prog_hi, 9), 8'hFF);
      send_item(pcgt_pkg::CMD_MIDI, 8'h95, slot7(cfg_prog_lo, cfg_prog_hi, 1), 8'd0);
      send_item(pcgt_pkg::CMD_MIDI, 8'hFF, 7'h7F, 8'hFF);
      send_item(pcgt_pkg::CMD_MIDI, 8'h00, 7'h00, 8'h00);
      send_tick(8'd0);
   endtask

   // Every slot shares one program, so a single program change fires all ten.
   // The bus map mixes unused, out-of-range and shared buses.
   task automatic test_all_slots();
      write_settings({5{7'h2A}}, {5{7'h2A}}, 35'({$urandom, $urandom}), '1,
                     35'({5'd31, 5'd29, 5'd0, 5'd28, 5'd1}),
                     35'({5'd31, 5'd5, 5'd5, 5'd28, 5'd1}),
                     35'd16, 35'(pcgt_pkg::DEST_MAX));
      send_item(pcgt_pkg::CMD_MIDI, 8'hC3, 7'h2A, 8'd0);
      repeat (5) send_tick(8'hFF);
   endtask

   // A note that sounds while the destination is switched off stays marked and
   // gets its note-off once a port is selected again.
   task automatic test_silent_destination();
      settle_block();
      write_reg(pcgt_pkg::REG_DEST, 35'd3);
      write_reg(pcgt_pkg::REG_CHANNEL, 35'd0);
      write_reg(pcgt_pkg::REG_BUS_LO, 35'({5'd0, 5'd0, 5'd7, 5'd0, 5'd0}));
      send_item(pcgt_pkg::CMD_MIDI, 8'hC9, slot7(cfg_prog_lo, cfg_prog_hi, 2), 8'd0);
      settle_block();
      write_reg(pcgt_pkg::REG_DEST, 35'd0);
      repeat (5) send_tick(8'hFF);
      settle_block();
      write_reg(pcgt_pkg::REG_DEST, 35'd7);
      send_item(pcgt_pkg::CMD_MIDI, 8'hC1, slot7(cfg_prog_lo, cfg_prog_hi, 2), 8'd0);
      settle_block();
      write_reg(pcgt_pkg::REG_DEST, 35'd1);
      write_reg(pcgt_pkg::REG_CHANNEL, 35'd17);
      repeat (5) send_tick(8'hFF);
   endtask

   task automatic test_random_traffic();
      logic [pcgt_pkg::WIDE_REG_W-1:0] prog_lo, prog_hi;
      logic [pcgt_pkg::WIDE_REG_W-1:0] dest;
      int                              pick;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         for (int i = 0; i < 4; i++)
            program_pool[i] = (phase == 0) ? 7'h00 : (phase == 1) ? 7'h7F : 7'($urandom);
         if (phase == 0) begin
            write_settings('0, '0, '0, '0, '0, '0, '0, '0);
         end else if (phase == 1) begin
            write_settings('1, '1, '1, '1, '1, '1, '1, '1);
         end else begin
            for (int s = 0; s < pcgt_pkg::HALF_SLOTS; s++) begin
               prog_lo[pcgt_pkg::PROG_W * s +: pcgt_pkg::PROG_W] = pick_program();
               prog_hi[pcgt_pkg::PROG_W * s +: pcgt_pkg::PROG_W] = pick_program();
            end
            pick = $urandom_range(0, 11);
            dest = (pick < 8) ? 35'(pick) : 35'($urandom_range(1, 4));
            write_settings(prog_lo, prog_hi, 35'({$urandom, $urandom}),
                           35'({$urandom, $urandom}), 35'($urandom), 35'($urandom),
                           35'($urandom_range(0, 31)), dest);
         end
         if (phase == PHASE_COUNT - 1) begin
            req_gap_odds   = 0;
            rsp_stall_odds = 0;
         end else begin
            req_gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            rsp_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
               send_item(pcgt_pkg::CMD_MIDI, {pcgt_pkg::STATUS_PC_HI, 4'($urandom)},
                         pick_program(), 8'($urandom));
            else if (pick < 68)
               send_item(pcgt_pkg::CMD_MIDI, 8'($urandom), 7'($urandom), 8'($urandom));
            else if (pick < 74)
               send_tick(8'd0);
            else if (pick < 84)
               send_tick(8'hFF);
            else
               send_tick(8'($urandom));
            if (phase != PHASE_COUNT - 1 && $urandom_range(0, 49) == 0) settle_block();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_program_match();
      test_all_slots();
      test_silent_destination();
      test_random_traffic();
      settle_block();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_events.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/pcgt_pkg.sv
rtl/pcgt_ctrl.sv
rtl/pcgt_datapath.sv
rtl/program_change_gate_trigger.sv
dv/program_change_gate_trigger_tb.sv
